[design/sce_pkg.sv]
// ----------------------------------------------------------------------------
// sce_pkg
// Types and fixed constants for the sparse cross-entropy loss block.
// ----------------------------------------------------------------------------
package sce_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int LOG_FRAC    = FRAC_BITS + 4;
  localparam int PROB_W      = 17;
  localparam int LABEL_W     = 10;
  localparam int NC_W        = 11;
  localparam int MEAN_W      = 21;
  localparam int SUM_W       = 32;
  localparam int LOSS_W      = 20;
  localparam int DIVIDEND_W  = SUM_W + 1;
  localparam int MAX_CLASSES = 1024;
  localparam int LN2_SHIFT   = 28;

  localparam logic [NC_W-1:0]   NC_RESET    = NC_W'(10);
  localparam logic [NC_W-1:0]   NC_MAX      = NC_W'(MAX_CLASSES);
  localparam logic [NC_W-1:0]   COUNT_MAX   = {NC_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX     = {SUM_W{1'b1}};
  localparam logic [MEAN_W-1:0] MEAN_MAX    = {MEAN_W{1'b1}};
  localparam logic [23:0]       LN2_Q24     = 24'd11629080;

  typedef struct packed {
    logic [PROB_W-1:0]  probability;
    logic [LABEL_W-1:0] class_label;
    logic               last_of_batch;
  } in_item_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_loss;
    logic              label_error;
  } out_item_t;

endpackage

[design/sce_ln.sv]
// ----------------------------------------------------------------------------
// sce_ln
// Iterative -ln(p) unit: log2 by repeated squaring on one shared multiplier,
// then scaling by ln 2 on the same multiplier.
// ----------------------------------------------------------------------------
module sce_ln (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sce_pkg::PROB_W-1:0] prob,
  output logic                       done,
  output logic [sce_pkg::LOSS_W-1:0] loss
);
  import sce_pkg::*;

  localparam int M_W    = 31;
  localparam int PROD_W = 2 * M_W;
  localparam int E_W    = 5;
  localparam int L2_W   = E_W + LOG_FRAC;
  localparam int ITER_W = $clog2(LOG_FRAC);

  localparam logic [PROB_W-1:0] ONE = PROB_W'(1 << FRAC_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_NORM,
    S_SCALE,
    S_ROUND
  } state_t;

  state_t              state;
  logic [M_W-1:0]      m;
  logic [LOG_FRAC-1:0] f;
  logic [E_W-1:0]      e;
  logic [ITER_W-1:0]   iter;
  logic [PROD_W-1:0]   prod;

  logic [PROB_W-1:0]   x;
  logic [E_W-1:0]      e_start;
  logic [M_W-1:0]      m_start;
  logic [M_W:0]        sq;
  logic [L2_W-1:0]     l2;
  logic [M_W-1:0]      mult_a;
  logic [M_W-1:0]      mult_b;
  logic [PROD_W-1:0]   prod_next;
  logic [PROD_W-1:0]   rounded;

  always_comb begin
    if (prob == '0) begin
      x = PROB_W'(1);
    end else if (prob > ONE) begin
      x = ONE;
    end else begin
      x = prob;
    end
    // leading one position
    e_start = '0;
    for (int i = 0; i < PROB_W; i++) begin
      if (x[i]) begin
        e_start = E_W'(i);
      end
    end
  end

  assign m_start = M_W'(x) << (E_W'(M_W - 1) - e_start);
  assign sq      = prod[PROD_W-1:M_W-1];
  assign l2      = {E_W'(FRAC_BITS) - e, {LOG_FRAC{1'b0}}} - L2_W'(f);

  // one multiplier: squaring during the log loop, ln 2 scaling at the end
  always_comb begin
    if (state == S_SCALE) begin
      mult_a = M_W'(l2);
      mult_b = M_W'(LN2_Q24);
    end else begin
      mult_a = m;
      mult_b = m;
    end
  end

  assign prod_next = PROD_W'(mult_a) * PROD_W'(mult_b);
  assign rounded   = prod + (PROD_W'(1) << (LN2_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            e     <= e_start;
            m     <= m_start;
            f     <= '0;
            iter  <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          prod  <= prod_next;
          state <= S_NORM;
        end
        S_NORM: begin
          // square reached 2.0: halve and take a one
          if (sq[M_W]) begin
            m <= sq[M_W:1];
            f <= {f[LOG_FRAC-2:0], 1'b1};
          end else begin
            m <= sq[M_W-1:0];
            f <= {f[LOG_FRAC-2:0], 1'b0};
          end
          iter <= iter + ITER_W'(1);
          if (iter == ITER_W'(LOG_FRAC - 1)) begin
            state <= S_SCALE;
          end else begin
            state <= S_SQ;
          end
        end
        S_SCALE: begin
          prod  <= prod_next;
          state <= S_ROUND;
        end
        S_ROUND: begin
          loss  <= rounded[LN2_SHIFT+LOSS_W-1:LN2_SHIFT];
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/sce_div.sv]
// ----------------------------------------------------------------------------
// sce_div
// Restoring divider, one quotient bit per cycle, for the batch mean.
// ----------------------------------------------------------------------------
module sce_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [sce_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [sce_pkg::NC_W-1:0]       divisor,
  output logic                           done,
  output logic [sce_pkg::DIVIDEND_W-1:0] quotient
);
  import sce_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t          state;
  logic [NC_W-1:0] rem;
  logic [NC_W-1:0] dvsr;
  logic [CNT_W-1:0] cnt;

  logic [NC_W:0]   rem_sh;
  logic [NC_W:0]   diff;

  assign rem_sh = {rem, quotient[DIVIDEND_W-1]};
  assign diff   = rem_sh - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            quotient <= dividend;
            dvsr     <= divisor;
            rem      <= '0;
            cnt      <= '0;
            state    <= S_RUN;
          end
        end
        S_RUN: begin
          if (rem_sh >= {1'b0, dvsr}) begin
            rem      <= diff[NC_W-1:0];
            quotient <= {quotient[DIVIDEND_W-2:0], 1'b1};
          end else begin
            rem      <= rem_sh[NC_W-1:0];
            quotient <= {quotient[DIVIDEND_W-2:0], 1'b0};
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/sparse_cross_entropy_loss_top.sv]
// ----------------------------------------------------------------------------
// sparse_cross_entropy_loss_top
// Streams class probabilities, accumulates -ln(p) at the true class of each
// sample and emits the rounded mean loss at the end of a batch.
//
//   channel  direction  handshake            payload
//   in       into       in_valid / in_stall  in_data  (probability, label, last)
//   out      out of     out_valid/out_stall  out_data (mean_loss, label_error)
//   cfg      into       cfg_wr_en            cfg_wr_data (class count)
//
// an item away from the true class leaves the block idle for the next item
// the item at the true class waits on the log unit, which squares twenty
// times on its one multiplier, a multiply state and a normalise state each
// the last item of a batch also waits on the bit-serial divider
// synchronous reset; the class count resets to 10, the batch state to zero
// in_stall is high while an item is at work; a result waiting on a stalled
// output register holds the block, and the input with it, until it drains
// ----------------------------------------------------------------------------
module sparse_cross_entropy_loss_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  sce_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output sce_pkg::out_item_t       out_data,
  input  logic                     cfg_wr_en,
  input  logic [sce_pkg::NC_W-1:0] cfg_wr_data
);
  import sce_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LN,
    S_DIV_GO,
    S_DIV,
    S_EMIT
  } state_t;

  state_t               state;
  logic [NC_W-1:0]      class_count;
  logic [LABEL_W-1:0]   class_position;
  logic [NC_W-1:0]      sample_count;
  logic [SUM_W-1:0]     loss_sum;
  logic                 error_seen;
  logic                 last;
  logic [DIVIDEND_W-1:0] mean_raw;

  logic                 accept;
  logic [NC_W-1:0]      n;
  logic                 label_ok;
  logic                 match;
  logic                 end_sample;
  logic [NC_W-1:0]      pos_inc;
  logic                 ln_done;
  logic [LOSS_W-1:0]    ln_loss;
  logic [SUM_W:0]       sum_add;
  logic [NC_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] dividend;
  logic                 div_done;
  logic [DIVIDEND_W-1:0] quotient;
  logic                 out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (class_count == '0) begin
      n = NC_W'(1);
    end else if (class_count > NC_MAX) begin
      n = NC_MAX;
    end else begin
      n = class_count;
    end
  end

  assign label_ok   = {1'b0, in_data.class_label} < n;
  assign match      = label_ok && (class_position == in_data.class_label);
  assign pos_inc    = {1'b0, class_position} + NC_W'(1);
  assign end_sample = (pos_inc >= n) || in_data.last_of_batch;

  assign sum_add  = {1'b0, loss_sum} + (SUM_W + 1)'(ln_loss);
  assign cnt      = (sample_count == '0) ? NC_W'(1) : sample_count;
  assign dividend = {1'b0, loss_sum} + DIVIDEND_W'(cnt >> 1);
  assign out_free = !out_valid || !out_stall;

  sce_ln u_ln (
    .clk  (clk),
    .rst  (rst),
    .start(accept && match),
    .prob (in_data.probability),
    .done (ln_done),
    .loss (ln_loss)
  );

  sce_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_DIV_GO),
    .dividend(dividend),
    .divisor (cnt),
    .done    (div_done),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      class_count    <= NC_RESET;
      class_position <= '0;
      sample_count   <= '0;
      loss_sum       <= '0;
      error_seen     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        class_count <= cfg_wr_data;
      end
      // a new result may enter as the old one leaves
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last <= in_data.last_of_batch;
            if (!label_ok) begin
              error_seen <= 1'b1;
            end
            if (end_sample) begin
              class_position <= '0;
              if (sample_count < COUNT_MAX) begin
                sample_count <= sample_count + NC_W'(1);
              end
            end else begin
              class_position <= pos_inc[LABEL_W-1:0];
            end
            if (match) begin
              state <= S_LN;
            end else if (in_data.last_of_batch) begin
              state <= S_DIV_GO;
            end
          end
        end
        S_LN: begin
          if (ln_done) begin
            loss_sum <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            state    <= last ? S_DIV_GO : S_IDLE;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            mean_raw <= quotient;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          // wait for room in the output register
          if (out_free) begin
            out_data.mean_loss <= (mean_raw > DIVIDEND_W'(MEAN_MAX)) ?
                                  MEAN_MAX : mean_raw[MEAN_W-1:0];
            out_data.label_error <= error_seen;
            sample_count <= '0;
            loss_sum     <= '0;
            error_seen   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
